// ===== src/gdmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdmd_pkg
// Shared widths, calendar constants, beat types and month tables for the
// Gregorian date minus days core.
// ----------------------------------------------------------------------------
package gdmd_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int DAYS_BACK_W = 22;
  localparam int CUM_W       = 9;

  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  localparam int YEARS_400 = 400;
  localparam int YEARS_100 = 100;
  localparam int YEARS_4   = 4;
  localparam int YEARS_1   = 1;

  localparam int Q100_W = 2;
  localparam int Q4_W   = 5;
  localparam int Q1_W   = 2;

  // last four-year group of a century
  localparam logic [Q4_W-1:0]   Q4_CENTURY_END = 5'd24;
  localparam logic [Q1_W-1:0]   Q1_LAST        = 2'd3;
  localparam logic [Q100_W-1:0] Q100_LAST      = 2'd3;

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic op;
  } alu_ctl_t;

  typedef struct packed {
    logic [DAY_W-1:0]       day_in;
    logic [MONTH_W-1:0]     month_in;
    logic [YEAR_W-1:0]      year_in;
    logic [DAYS_BACK_W-1:0] days_back;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;
    logic               clamped;
  } rsp_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      FEB:                len = leap ? 5'd29 : 5'd28;
      APR, JUN, SEP, NOV: len = 5'd30;
      default:            len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [CUM_W-1:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > FEB)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  function automatic logic leap_of(input logic [Q100_W-1:0] q100,
                                   input logic [Q4_W-1:0] q4,
                                   input logic [Q1_W-1:0] q1);
    return (q1 == Q1_LAST) && ((q4 != Q4_CENTURY_END) || (q100 == Q100_LAST));
  endfunction

endpackage

// ===== src/gdmd_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdmd_alu
// Shared add/subtract unit with an unsigned greater-or-equal flag.
// ----------------------------------------------------------------------------
module gdmd_alu import gdmd_pkg::*; #(
  parameter int W = 22
) (
  input  alu_ctl_t       ctl,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output logic           ge
);

  logic [W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[W];
  assign res  = (ctl.op == ALU_SUB) ? diff[W-1:0] : (a + b);

endmodule

// ===== src/gregorian_date_minus_days_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_minus_days_core
// Steps a proleptic Gregorian date back by a count of days, saturating at
// the first day of year one.
// ----------------------------------------------------------------------------
//  channel | signals                     | beat
//  --------+-----------------------------+-------------------------------
//  req     | req_valid, req_stall, req   | day, month, year, days back
//  rsp     | rsp_valid, rsp_stall, rsp   | day, month, year, clamped flag
//
//  Each beat is worked through the restoring quotient steps and the month
//  walk, all through the one shared adder.
//  req_stall is high from acceptance until the result is in the output
//  register; a stalled rsp beat holds while the next req beat is taken.
//  Synchronous reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module gregorian_date_minus_days_core import gdmd_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int ORD_W  = $clog2(MAX_YEAR * 366 + 1);
  localparam int ALU_W  = (ORD_W > DAYS_BACK_W) ? ORD_W : DAYS_BACK_W;
  localparam int Q400_W = $clog2(MAX_YEAR / 400 + 1);
  localparam int IDX_W  = ($clog2(Q400_W) > 3) ? $clog2(Q400_W) : 3;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_E400 = 5'd1;
  localparam logic [4:0] S_E100 = 5'd2;
  localparam logic [4:0] S_E4   = 5'd3;
  localparam logic [4:0] S_E1   = 5'd4;
  localparam logic [4:0] S_A400 = 5'd5;
  localparam logic [4:0] S_A100 = 5'd6;
  localparam logic [4:0] S_A4   = 5'd7;
  localparam logic [4:0] S_A1   = 5'd8;
  localparam logic [4:0] S_AMON = 5'd9;
  localparam logic [4:0] S_ADAY = 5'd10;
  localparam logic [4:0] S_SUB  = 5'd11;
  localparam logic [4:0] S_D400 = 5'd12;
  localparam logic [4:0] S_D100 = 5'd13;
  localparam logic [4:0] S_D4   = 5'd14;
  localparam logic [4:0] S_D1   = 5'd15;
  localparam logic [4:0] S_YEAR = 5'd16;
  localparam logic [4:0] S_DMON = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [4:0]             state;
  logic [IDX_W-1:0]       idx;
  logic [YEAR_W-1:0]      p;
  logic [ALU_W-1:0]       n;
  logic [DAYS_BACK_W-1:0] kreg;
  logic [MONTH_W-1:0]     mon;
  logic [DAY_W-1:0]       dreg;
  logic [Q400_W-1:0]      qa;
  logic [Q100_W-1:0]      qb;
  logic [Q4_W-1:0]        qc;
  logic [Q1_W-1:0]        qd;
  logic [YEAR_W-1:0]      yr;
  logic                   flag;
  rsp_t                   result;

  logic                   accept;
  logic [MONTH_W-1:0]     m_norm;
  logic [YEAR_W-1:0]      y_norm;
  logic                   leap;
  logic [DAY_W-1:0]       dl;
  logic [DAY_W-1:0]       dd;
  alu_ctl_t               ctl;
  logic [ALU_W-1:0]       opa;
  logic [ALU_W-1:0]       opb;
  logic [ALU_W-1:0]       res;
  logic                   ge;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp       = result;

  always_comb begin
    m_norm = req.month_in;
    if (req.month_in < JAN) begin
      m_norm = JAN;
    end else if (req.month_in > DEC) begin
      m_norm = DEC;
    end
    y_norm = req.year_in;
    if (req.year_in == '0) begin
      y_norm = YEAR_W'(1);
    end else if (32'(req.year_in) > MAX_YEAR) begin
      y_norm = YEAR_W'(MAX_YEAR);
    end
  end

  assign leap = leap_of(qb, qc, qd);
  assign dl   = month_len(mon, leap);

  always_comb begin
    dd = dreg;
    if (dreg == '0) begin
      dd = DAY_W'(1);
    end else if (dreg > dl) begin
      dd = dl;
    end
  end

  always_comb begin
    ctl.op = ALU_SUB;
    opa    = n;
    case (state)
      S_E400: begin
        opa = ALU_W'(p);
        opb = ALU_W'(YEARS_400) << idx;
      end
      S_E100: begin
        opa = ALU_W'(p);
        opb = ALU_W'(YEARS_100) << idx;
      end
      S_E4: begin
        opa = ALU_W'(p);
        opb = ALU_W'(YEARS_4) << idx;
      end
      S_E1: begin
        opa = ALU_W'(p);
        opb = ALU_W'(YEARS_1) << idx;
      end
      S_A400: begin
        ctl.op = ALU_ADD;
        opb    = ALU_W'(32'(qa) * DAYS_400Y);
      end
      S_A100: begin
        ctl.op = ALU_ADD;
        opb    = ALU_W'(32'(qb) * DAYS_100Y);
      end
      S_A4: begin
        ctl.op = ALU_ADD;
        opb    = ALU_W'(32'(qc) * DAYS_4Y);
      end
      S_A1: begin
        ctl.op = ALU_ADD;
        opb    = ALU_W'(32'(qd) * DAYS_1Y);
      end
      S_AMON: begin
        ctl.op = ALU_ADD;
        opb    = ALU_W'(cum_days(mon, leap));
      end
      S_ADAY: begin
        ctl.op = ALU_ADD;
        opb    = ALU_W'(dd - DAY_W'(1));
      end
      S_SUB:   opb = ALU_W'(kreg);
      S_D400:  opb = ALU_W'(DAYS_400Y) << idx;
      S_D100:  opb = ALU_W'(DAYS_100Y) << idx;
      S_D4:    opb = ALU_W'(DAYS_4Y) << idx;
      S_D1:    opb = ALU_W'(DAYS_1Y) << idx;
      S_DMON:  opb = ALU_W'(dl);
      default: opb = '0;
    endcase
  end

  gdmd_alu #(
    .W (ALU_W)
  ) u_alu (
    .ctl (ctl),
    .a   (opa),
    .b   (opb),
    .res (res),
    .ge  (ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mon   <= m_norm;
            p     <= y_norm - YEAR_W'(1);
            dreg  <= req.day_in;
            kreg  <= req.days_back;
            n     <= '0;
            idx   <= IDX_W'(Q400_W - 1);
            state <= S_E400;
          end
        end
        S_E400: begin
          if (ge) p <= res[YEAR_W-1:0];
          qa <= Q400_W'({qa, ge});
          if (idx == '0) begin
            idx   <= IDX_W'(Q100_W - 1);
            state <= S_E100;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_E100: begin
          if (ge) p <= res[YEAR_W-1:0];
          qb <= Q100_W'({qb, ge});
          if (idx == '0) begin
            idx   <= IDX_W'(Q4_W - 1);
            state <= S_E4;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_E4: begin
          if (ge) p <= res[YEAR_W-1:0];
          qc <= Q4_W'({qc, ge});
          if (idx == '0) begin
            idx   <= IDX_W'(Q1_W - 1);
            state <= S_E1;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_E1: begin
          if (ge) p <= res[YEAR_W-1:0];
          qd <= Q1_W'({qd, ge});
          if (idx == '0) begin
            state <= S_A400;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_A400: begin
          n     <= res;
          state <= S_A100;
        end
        S_A100: begin
          n     <= res;
          state <= S_A4;
        end
        S_A4: begin
          n     <= res;
          state <= S_A1;
        end
        S_A1: begin
          n     <= res;
          state <= S_AMON;
        end
        S_AMON: begin
          n     <= res;
          state <= S_ADAY;
        end
        S_ADAY: begin
          n     <= res;
          state <= S_SUB;
        end
        S_SUB: begin
          if (ge) begin
            n    <= res;
            flag <= 1'b0;
          end else begin
            n    <= '0;
            flag <= 1'b1;
          end
          idx   <= IDX_W'(Q400_W - 1);
          state <= S_D400;
        end
        S_D400: begin
          if (ge) n <= res;
          qa <= Q400_W'({qa, ge});
          if (idx == '0) begin
            idx   <= IDX_W'(Q100_W - 1);
            state <= S_D100;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_D100: begin
          if (ge) n <= res;
          qb <= Q100_W'({qb, ge});
          if (idx == '0) begin
            idx   <= IDX_W'(Q4_W - 1);
            state <= S_D4;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_D4: begin
          if (ge) n <= res;
          qc <= Q4_W'({qc, ge});
          if (idx == '0) begin
            idx   <= IDX_W'(Q1_W - 1);
            state <= S_D1;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_D1: begin
          if (ge) n <= res;
          qd <= Q1_W'({qd, ge});
          if (idx == '0) begin
            state <= S_YEAR;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_YEAR: begin
          yr    <= YEAR_W'(32'(qa) * YEARS_400 + 32'(qb) * YEARS_100 +
                           32'(qc) * YEARS_4 + 32'(qd) + 32'd1);
          mon   <= JAN;
          state <= S_DMON;
        end
        S_DMON: begin
          if (ge && (mon != DEC)) begin
            n   <= res;
            mon <= mon + MONTH_W'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            result.day_out   <= n[DAY_W-1:0] + DAY_W'(1);
            result.month_out <= mon;
            result.year_out  <= yr;
            result.clamped   <= flag;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_gregorian_date_minus_days_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_minus_days_core
// Drives dates and day counts into the core in random bursts, with the
// result side stalling in shifting patterns. Each result beat is checked
// field by field against an in-order calendar computation done here:
// clamp the input date, turn it into a day number, step back, and walk
// the years and months forward again.
// ----------------------------------------------------------------------------
module tb_gregorian_date_minus_days_core;
  import gdmd_pkg::*;

  localparam int LAST_YEAR   = 9999;
  localparam int N_RANDOM    = 1700;
  localparam int DRAIN_EVERY = 400;
  localparam int TAIL_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  bit   drain_before[$];
  rsp_t due_dates[$];

  int   n_items;
  int   taken_cnt;
  int   err_cnt;
  int   burst_left = 1;
  int   gap_left;
  int   stall_mode;
  int   mode_left;
  int   tick;
  rsp_t want;

  gregorian_date_minus_days_core #(
    .MAX_YEAR(LAST_YEAR)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned mon_days(int unsigned m, int unsigned y);
    int unsigned len;
    len = 31;
    if (m == 32'(FEB)) begin
      len = is_leap(y) ? 29 : 28;
    end else if (m == 32'(APR) || m == 32'(JUN) || m == 32'(SEP) || m == 32'(NOV)) begin
      len = 30;
    end
    return len;
  endfunction

  function automatic int unsigned day_number(int unsigned d, int unsigned m,
                                             int unsigned y);
    int unsigned p;
    int unsigned n;
    int unsigned i;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (i = 1; i < m; i++) begin
      n += mon_days(i, y);
    end
    return n + d;
  endfunction

  function automatic rsp_t earlier_date(req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned k;
    int unsigned n;
    rsp_t o;
    d = 32'(r.day_in);
    m = 32'(r.month_in);
    y = 32'(r.year_in);
    k = 32'(r.days_back);
    if (m < 32'(JAN)) m = 32'(JAN);
    if (m > 32'(DEC)) m = 32'(DEC);
    if (y < 1) y = 1;
    if (y > LAST_YEAR) y = LAST_YEAR;
    if (d < 1) d = 1;
    if (d > mon_days(m, y)) d = mon_days(m, y);
    n = day_number(d, m, y);
    o.clamped = (k >= n);
    // zero-based day count from 1/1/1
    n = (k >= n) ? 0 : n - k - 1;
    y = 1 + 400 * (n / 146097);
    n = n % 146097;
    while (n >= year_days(y)) begin
      n -= year_days(y);
      y++;
    end
    m = 32'(JAN);
    while (n >= mon_days(m, y)) begin
      n -= mon_days(m, y);
      m++;
    end
    o.day_out   = DAY_W'(n + 1);
    o.month_out = MONTH_W'(m);
    o.year_out  = YEAR_W'(y);
    return o;
  endfunction

  function automatic req_t make_req(int unsigned d, int unsigned m, int unsigned y,
                                    int unsigned k);
    req_t r;
    r.day_in    = DAY_W'(d);
    r.month_in  = MONTH_W'(m);
    r.year_in   = YEAR_W'(y);
    r.days_back = DAYS_BACK_W'(k);
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    if ($urandom_range(0, 9) == 0) begin
      return make_req($urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, 16383), $urandom_range(0, 22'h3FFFFF));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      y = $urandom_range(1, LAST_YEAR);
    end else if (pick < 8) begin
      y = 100 * $urandom_range(1, 99) - 1 + $urandom_range(0, 2);
    end else if (pick < 9) begin
      y = $urandom_range(1, 12);
    end else begin
      y = $urandom_range(LAST_YEAR - 9, LAST_YEAR);
    end
    m = $urandom_range(32'(JAN), 32'(DEC));
    d = ($urandom_range(0, 3) == 0) ? mon_days(m, y) : $urandom_range(1, mon_days(m, y));
    n = day_number(d, m, y);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      k = $urandom_range(0, n - 1);
    end else if (pick < 60) begin
      k = $urandom_range(0, 800);
    end else if (pick < 70) begin
      k = (n > 2) ? n - 2 + $urandom_range(0, 4) : $urandom_range(0, 3);
    end else if (pick < 85) begin
      k = $urandom_range(0, 3652059);
    end else begin
      k = $urandom_range(0, 22'h3FFFFF);
    end
    return make_req(d, m, y, k);
  endfunction

  task automatic add_item(req_t r, bit drain);
    pending_reqs.push_back(r);
    drain_before.push_back(drain);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // driver: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (gap_left != 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (drain_before[0] && (req_valid || due_dates.size() != 0))) begin
        req_valid <= 1'b0;
      end else begin
        req <= pending_reqs.pop_front();
        void'(drain_before.pop_front());
        req_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(0, 80);
          end
        end
      end
    end
  end

  // result side stall pattern
  always @(posedge clk) begin
    tick++;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 1) == 1);
        2: rsp_stall <= ($urandom_range(0, 7) != 0);
        default: rsp_stall <= ((tick % 37) < 20);
      endcase
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        due_dates.push_back(earlier_date(req));
        taken_cnt++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_dates.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, rsp);
          err_cnt++;
        end else begin
          want = due_dates.pop_front();
          check_field("day_out", 32'(want.day_out), 32'(rsp.day_out));
          check_field("month_out", 32'(want.month_out), 32'(rsp.month_out));
          check_field("year_out", 32'(want.year_out), 32'(rsp.year_out));
          check_field("clamped", 32'(want.clamped), 32'(rsp.clamped));
        end
      end
    end
  end

  initial begin
    add_item(make_req(1, 1, 1, 0), 1'b0);
    add_item(make_req(1, 1, 1, 1), 1'b0);
    add_item(make_req(2, 1, 1, 1), 1'b0);
    add_item(make_req(31, 12, LAST_YEAR, 0), 1'b0);
    add_item(make_req(31, 12, LAST_YEAR, 3652058), 1'b0);
    add_item(make_req(31, 12, LAST_YEAR, 3652059), 1'b0);
    add_item(make_req(31, 12, LAST_YEAR, 22'h3FFFFF), 1'b0);
    add_item(make_req(1, 3, 2000, 1), 1'b0);
    add_item(make_req(1, 3, 1900, 1), 1'b0);
    add_item(make_req(1, 3, 2004, 1), 1'b0);
    add_item(make_req(1, 3, 2001, 1), 1'b0);
    add_item(make_req(1, 1, 2000, 1), 1'b0);
    add_item(make_req(1, 1, 401, 1), 1'b0);
    add_item(make_req(15, 0, 1999, 0), 1'b0);
    add_item(make_req(15, 13, 1999, 0), 1'b0);
    add_item(make_req(15, 15, 1999, 40), 1'b0);
    add_item(make_req(10, 6, 0, 0), 1'b0);
    add_item(make_req(10, 6, 16383, 0), 1'b0);
    add_item(make_req(0, 5, 2020, 0), 1'b0);
    add_item(make_req(31, 2, 2001, 0), 1'b0);
    add_item(make_req(31, 4, 2023, 0), 1'b0);
    add_item(make_req(30, 2, 2000, 0), 1'b0);
    add_item(make_req(31, 15, 16383, 0), 1'b0);
    add_item(make_req(31, 15, 16383, 22'h3FFFFF), 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_item(random_req(), (i % DRAIN_EVERY) == 0);
    end
    n_items = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt != n_items) @(posedge clk);
    while (due_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (due_dates.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_dates.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
